// ----- rtl/waypoint_leg_geometry_macros.svh -----
// Assertion macros for the waypoint leg geometry checker.
// No dependencies; included by the checker file only.
`ifndef WAYPOINT_LEG_GEOMETRY_MACROS_SVH
`define WAYPOINT_LEG_GEOMETRY_MACROS_SVH

// clocked property, masked during reset
`define WLG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must never be seen while a request is on the output
`define WLG_OUT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        m_valid |-> !(expr)) else $error(msg);

`endif

// ----- rtl/wlg_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the leg geometry block.
// No dependencies.
package wlg_pkg;

    localparam int CW        = 60;
    localparam int PRE_SH    = 24;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 32;

    localparam logic [15:0] FULL_CIRCLE = 16'd36000;
    localparam logic [31:0] HALF_TURN   = 32'h8000_0000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
        logic                 zero;
    } cordic_t;

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] dq;
        logic [31:0] len;
        logic        sat;
    } div_t;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/wlg_cordic_cell.sv -----
// One vectoring CORDIC iteration, registered.
// Depends on wlg_pkg (cordic_t, atan_turn).
module wlg_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  wlg_pkg::cordic_t din,
    output wlg_pkg::cordic_t dout
);
    import wlg_pkg::*;

    cordic_t              cell_reg, cell_next;
    logic signed [CW-1:0] xi, yi;

    assign xi = din.x;
    assign yi = din.y;

    always_comb begin
        cell_next = din;
        if (!yi[CW-1]) begin
            cell_next.x = xi + (yi >>> IDX);
            cell_next.y = yi - (xi >>> IDX);
            cell_next.z = din.z + atan_turn(5'(IDX));
        end else begin
            cell_next.x = xi - (yi >>> IDX);
            cell_next.y = yi + (xi >>> IDX);
            cell_next.z = din.z - atan_turn(5'(IDX));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ----- rtl/wlg_sqrt_cell.sv -----
// One digit step of the integer square root, registered.
// Depends on wlg_pkg (sqrt_t).
module wlg_sqrt_cell (
    input  logic           aclk,
    input  logic           en,
    input  wlg_pkg::sqrt_t din,
    output wlg_pkg::sqrt_t dout
);
    import wlg_pkg::*;

    sqrt_t       cell_reg, cell_next;
    logic [33:0] r4, trial;
    logic        ge;

    assign r4    = {din.rem[31:0], din.rad[63:62]};
    assign trial = {din.root, 2'b01};
    assign ge    = (r4 >= trial);

    always_comb begin
        cell_next.rad  = {din.rad[61:0], 2'b00};
        cell_next.rem  = ge ? (r4 - trial) : r4;
        cell_next.root = {din.root[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ----- rtl/wlg_div_cell.sv -----
// One restoring division step, quotient bit shifted in below the dividend.
// Depends on wlg_pkg (div_t).
module wlg_div_cell (
    input  logic          aclk,
    input  logic          en,
    input  wlg_pkg::div_t din,
    output wlg_pkg::div_t dout
);
    import wlg_pkg::*;

    div_t        cell_reg, cell_next;
    logic [33:0] r, dl;
    logic        ge;

    assign r  = {din.rem, din.dq[31]};
    assign dl = {2'b00, din.len};
    assign ge = (r >= dl);

    always_comb begin
        cell_next     = din;
        cell_next.rem = ge ? 33'(r - dl) : r[32:0];
        cell_next.dq  = {din.dq[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ----- rtl/waypoint_leg_geometry.sv -----
// Top level of the waypoint leg geometry pipeline.
// Depends on wlg_pkg, wlg_cordic_cell, wlg_sqrt_cell, wlg_div_cell.
//
// Usage:
//   Input channel s_*: one request carries waypoints A, B and aircraft P
//   (31-bit signed centimetres). Output channel m_*: leg bearing, bearing
//   from P to A (hundredths of a degree), cross-track distance, leg length
//   and the degenerate-leg flag.
//   Throughput: one request per cycle while the output is not stalled,
//   set by a single pipeline of cells (difference, products, 32 root cells,
//   32 divide cells, CORDIC_STAGES angle cells per bearing) all advancing
//   together.
//   Stall: while m_valid is high and m_ready low the whole pipeline holds
//   and s_ready is low; s_ready is high whenever the output register is
//   empty or being taken.
//   Reset (aresetn low, synchronous): all valid flags clear, no request
//   is in flight; payload registers are not reset.
//   A equal to B gives degenerate_leg 1 with zero length and cross track.
module waypoint_leg_geometry #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [30:0] s_waypoint_a_x,
    input  logic signed [30:0] s_waypoint_a_y,
    input  logic signed [30:0] s_waypoint_b_x,
    input  logic signed [30:0] s_waypoint_b_y,
    input  logic signed [30:0] s_aircraft_x,
    input  logic signed [30:0] s_aircraft_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_leg_bearing,
    output logic [15:0]        m_bearing_to_waypoint,
    output logic [31:0]        m_cross_track,
    output logic [31:0]        m_leg_length,
    output logic               m_degenerate_leg
);
    import wlg_pkg::*;

    localparam int LAT     = 69;
    localparam int BRG_DLY = 65 - CORDIC_STAGES;

    function automatic cordic_t cordic_prep(input logic signed [31:0] e,
                                            input logic signed [31:0] n);
        cordic_t              c;
        logic signed [CW-1:0] es, ns;
        es     = CW'(e) <<< PRE_SH;
        ns     = CW'(n) <<< PRE_SH;
        c.zero = (e == 32'sd0) && (n == 32'sd0);
        if (n[31]) begin
            c.x = -ns;
            c.y = -es;
            c.z = HALF_TURN;
        end else begin
            c.x = ns;
            c.y = es;
            c.z = '0;
        end
        return c;
    endfunction

    function automatic logic [15:0] to_hund(input logic [47:0] p, input logic zero);
        logic [15:0] h;
        h = p[47:32];
        if (zero || h >= FULL_CIRCLE) begin
            h = '0;
        end
        return h;
    endfunction

    logic adv;
    logic [LAT-1:0] vld_reg;
    logic m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[LAT-2:0], s_valid};
            m_valid_reg <= vld_reg[LAT-1];
        end
    end

    // differences
    logic signed [31:0] dx_reg, dy_reg, ex_reg, ey_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg <= {s_waypoint_b_x[30], s_waypoint_b_x}
                    - {s_waypoint_a_x[30], s_waypoint_a_x};
            dy_reg <= {s_waypoint_b_y[30], s_waypoint_b_y}
                    - {s_waypoint_a_y[30], s_waypoint_a_y};
            ex_reg <= {s_waypoint_a_x[30], s_waypoint_a_x}
                    - {s_aircraft_x[30], s_aircraft_x};
            ey_reg <= {s_waypoint_a_y[30], s_waypoint_a_y}
                    - {s_aircraft_y[30], s_aircraft_y};
        end
    end

    // products and CORDIC entry
    logic signed [63:0] pxx_reg, pyy_reg, pxe_reg, pye_reg;
    cordic_t            leg_c [CORDIC_STAGES+1];
    cordic_t            wpt_c [CORDIC_STAGES+1];
    cordic_t            leg_in_reg, wpt_in_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pxx_reg    <= dx_reg * dx_reg;
            pyy_reg    <= dy_reg * dy_reg;
            pxe_reg    <= dx_reg * ey_reg;
            pye_reg    <= dy_reg * ex_reg;
            leg_in_reg <= cordic_prep(dx_reg, dy_reg);
            wpt_in_reg <= cordic_prep(ex_reg, ey_reg);
        end
    end

    assign leg_c[0] = leg_in_reg;
    assign wpt_c[0] = wpt_in_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        wlg_cordic_cell #(.IDX(i)) u_leg (
            .aclk(aclk), .en(adv), .din(leg_c[i]), .dout(leg_c[i+1])
        );
        wlg_cordic_cell #(.IDX(i)) u_wpt (
            .aclk(aclk), .en(adv), .din(wpt_c[i]), .dout(wpt_c[i+1])
        );
    end

    // angle to hundredths of a degree, then aligned to the output
    logic [47:0] leg_prod_reg, wpt_prod_reg;
    logic        leg_zero_reg, wpt_zero_reg;
    logic [15:0] leg_h_reg, wpt_h_reg;
    logic [15:0] leg_dly_reg [BRG_DLY];
    logic [15:0] wpt_dly_reg [BRG_DLY];

    always_ff @(posedge aclk) begin
        if (adv) begin
            leg_prod_reg   <= {16'd0, leg_c[CORDIC_STAGES].z} * 48'd36000
                            + 48'h0000_8000_0000;
            wpt_prod_reg   <= {16'd0, wpt_c[CORDIC_STAGES].z} * 48'd36000
                            + 48'h0000_8000_0000;
            leg_zero_reg   <= leg_c[CORDIC_STAGES].zero;
            wpt_zero_reg   <= wpt_c[CORDIC_STAGES].zero;
            leg_h_reg      <= to_hund(leg_prod_reg, leg_zero_reg);
            wpt_h_reg      <= to_hund(wpt_prod_reg, wpt_zero_reg);
            leg_dly_reg[0] <= leg_h_reg;
            wpt_dly_reg[0] <= wpt_h_reg;
            for (int k = 1; k < BRG_DLY; k++) begin
                leg_dly_reg[k] <= leg_dly_reg[k-1];
                wpt_dly_reg[k] <= wpt_dly_reg[k-1];
            end
        end
    end

    // squared length and cross product
    logic [63:0]        sq_reg;
    logic signed [63:0] cross_reg;
    logic [63:0]        n_dly_reg [SQ_STEPS+1];
    sqrt_t              sq_c [SQ_STEPS+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg       <= 64'(pxx_reg) + 64'(pyy_reg);
            cross_reg    <= pxe_reg - pye_reg;
            n_dly_reg[0] <= cross_reg[63] ? 64'(-cross_reg) : 64'(cross_reg);
            for (int k = 1; k <= SQ_STEPS; k++) begin
                n_dly_reg[k] <= n_dly_reg[k-1];
            end
        end
    end

    assign sq_c[0] = '{rad: sq_reg, rem: '0, root: '0};

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        wlg_sqrt_cell u_cell (
            .aclk(aclk), .en(adv), .din(sq_c[j]), .dout(sq_c[j+1])
        );
    end

    // rounded length, then divide setup
    logic [31:0] len_reg;
    logic [63:0] dvd;
    div_t        div_in_reg;
    div_t        dv_c [DIV_STEPS+1];

    assign dvd = n_dly_reg[SQ_STEPS] + {33'd0, len_reg[31:1]};

    always_ff @(posedge aclk) begin
        if (adv) begin
            len_reg <= sq_c[SQ_STEPS].root
                     + 32'(sq_c[SQ_STEPS].rem > {2'b00, sq_c[SQ_STEPS].root});
            div_in_reg.rem <= {1'b0, dvd[63:32]};
            div_in_reg.dq  <= dvd[31:0];
            div_in_reg.len <= len_reg;
            div_in_reg.sat <= (dvd[63:32] >= len_reg);
        end
    end

    assign dv_c[0] = div_in_reg;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        wlg_div_cell u_cell (
            .aclk(aclk), .en(adv), .din(dv_c[k]), .dout(dv_c[k+1])
        );
    end

    // output register
    logic        degen;
    logic [15:0] leg_out_reg, wpt_out_reg;
    logic [31:0] ct_out_reg, len_out_reg;
    logic        degen_out_reg;

    assign degen = (dv_c[DIV_STEPS].len == 32'd0);

    always_ff @(posedge aclk) begin
        if (adv) begin
            leg_out_reg   <= leg_dly_reg[BRG_DLY-1];
            wpt_out_reg   <= wpt_dly_reg[BRG_DLY-1];
            len_out_reg   <= dv_c[DIV_STEPS].len;
            degen_out_reg <= degen;
            if (degen) begin
                ct_out_reg <= '0;
            end else if (dv_c[DIV_STEPS].sat) begin
                ct_out_reg <= '1;
            end else begin
                ct_out_reg <= dv_c[DIV_STEPS].dq;
            end
        end
    end

    assign m_leg_bearing         = leg_out_reg;
    assign m_bearing_to_waypoint = wpt_out_reg;
    assign m_cross_track         = ct_out_reg;
    assign m_leg_length          = len_out_reg;
    assign m_degenerate_leg      = degen_out_reg;

endmodule

// ----- rtl/wlg_checker.sv -----
// Port-level checks for waypoint_leg_geometry, attached by bind.
// Depends on waypoint_leg_geometry_macros.svh.
`include "waypoint_leg_geometry_macros.svh"

module wlg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_leg_bearing,
    input logic [15:0] m_bearing_to_waypoint,
    input logic [31:0] m_cross_track,
    input logic [31:0] m_leg_length,
    input logic        m_degenerate_leg
);

    `WLG_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_leg_length) && $stable(m_cross_track), "output request changed while stalled")
    `WLG_ASSERT(a_ready_when_empty, !m_valid |-> s_ready, "input stalled with empty output")
    `WLG_OUT_NEVER(a_brg_range, m_leg_bearing >= 16'd36000 || m_bearing_to_waypoint >= 16'd36000, "bearing out of range")
    `WLG_OUT_NEVER(a_degen_zero, m_degenerate_leg && (m_cross_track != 32'd0 || m_leg_length != 32'd0), "degenerate leg with nonzero distance")
    `WLG_OUT_NEVER(a_len_nonzero, !m_degenerate_leg && m_leg_length == 32'd0, "zero length on a proper leg")

endmodule

bind waypoint_leg_geometry wlg_checker u_wlg_checker (.*);
